[design/modular_inverse_ext_euclid_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modular inverse block
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mie_pkg.sv]
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared constants and the status bundle of the iterative divide unit.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Default coefficient width
  localparam int COEF_BITS_DEF = 62;

  // Modulus after reset: 2^62 - 57
  localparam logic [61:0] MODULUS_RESET = 62'h3FFF_FFFF_FFFF_FFC7;

  // Status of the divide unit toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[design/mie_div_unit.sv]
// ----------------------------------------------------------------------------
// Modular inverse divide unit
// Restoring divider, one quotient bit per cycle, that also accumulates the
// product of the quotient and the current cofactor by shift and add.
// ----------------------------------------------------------------------------
module mie_div_unit #(
  parameter int COEF_BITS = mie_pkg::COEF_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COEF_BITS-1:0]    dividend_i,
  input  logic [COEF_BITS-1:0]    divisor_i,
  input  logic [COEF_BITS+1:0]    cofactor_i,
  output logic [COEF_BITS-1:0]    rem_o,
  output logic [COEF_BITS+1:0]    prod_o,
  output mie_pkg::div_status_t    status_o
);

  localparam int CW    = COEF_BITS + 2;
  localparam int CNT_W = $clog2(COEF_BITS);

  logic [COEF_BITS-1:0] rem_q, rem_d;
  logic [COEF_BITS-1:0] quo_q;
  logic [COEF_BITS-1:0] div_q;
  logic [CW-1:0]        cof_q;
  logic [CW-1:0]        prod_q, prod_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [COEF_BITS:0]   shifted;
  logic [COEF_BITS:0]   diff;
  logic                 qbit;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    shifted = {rem_q, quo_q[COEF_BITS-1]};
    diff    = shifted - {1'b0, div_q};
    qbit    = ~diff[COEF_BITS];
    rem_d   = qbit ? diff[COEF_BITS-1:0] : shifted[COEF_BITS-1:0];
    prod_d  = {prod_q[CW-2:0], 1'b0} + (qbit ? cof_q : '0);
  end

  // Control: load on start, then step until the count runs out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(COEF_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      div_q  <= divisor_i;
      cof_q  <= cofactor_i;
      prod_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[COEF_BITS-2:0], qbit};
      prod_q <= prod_d;
    end
  end

  assign rem_o    = rem_q;
  assign prod_o   = prod_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

[design/modular_inverse_ext_euclid_top.sv]
// ----------------------------------------------------------------------------
// Modular inverse, extended Euclidean algorithm
// Returns the inverse of one coefficient modulo the configured modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Write the modulus with cfg_we_i / cfg_wdata_i while the block is idle;
//   it resets to 2^62 - 57 (low COEF_BITS bits).
//   A request is taken at a clock edge with start high and busy low;
//   operand_value_i is sampled then. busy stays high until the result.
//   The result appears on inverse_value_o for exactly one cycle with
//   done_o high; the receiver cannot stall it, and busy is already low in
//   that cycle so the next request may be taken at once.
//   Each Euclid round runs the check state and then one pass of the
//   shared restoring divider, which produces one quotient bit per cycle;
//   a finish state ends each request. Up to about
//   1.44 * COEF_BITS + 2 rounds occur;
//   a zero modulus goes from the check state straight to finish.
//   Reset returns the sequencer to idle, drops any request in flight and
//   restores the modulus.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top #(
  parameter int COEF_BITS = mie_pkg::COEF_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [COEF_BITS-1:0] operand_value_i,
  input  logic                 cfg_we_i,
  input  logic [COEF_BITS-1:0] cfg_wdata_i,
  output logic                 done_o,
  output logic [COEF_BITS-1:0] inverse_value_o
);

  `include "modular_inverse_ext_euclid_top_assert.svh"

  localparam int CW = COEF_BITS + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [COEF_BITS-1:0] mod_q;
  logic [COEF_BITS-1:0] r_prev_q;
  logic [COEF_BITS-1:0] r_cur_q;
  logic [CW-1:0]        c_prev_q;
  logic [CW-1:0]        c_cur_q;
  logic                 div_start_q;
  logic                 done_q;
  logic [COEF_BITS-1:0] inverse_q;

  logic [COEF_BITS-1:0] div_rem;
  logic [CW-1:0]        div_prod;
  mie_pkg::div_status_t div_status;

  logic [CW-1:0]        c_sum;
  logic                 c_pos;
  logic [COEF_BITS-1:0] result_d;

  // Shared divide and multiply-accumulate unit
  mie_div_unit #(
    .COEF_BITS (COEF_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (r_prev_q),
    .divisor_i  (r_cur_q),
    .cofactor_i (c_cur_q),
    .rem_o      (div_rem),
    .prod_o     (div_prod),
    .status_o   (div_status)
  );

  // Make the final cofactor positive by adding the modulus when it is zero or negative
  always_comb begin
    c_sum    = c_prev_q + {2'b00, mod_q};
    c_pos    = (c_prev_q != '0) && !c_prev_q[CW-1];
    result_d = c_pos ? c_prev_q[COEF_BITS-1:0] : c_sum[COEF_BITS-1:0];
  end

  // Hold the modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mie_pkg::MODULUS_RESET[COEF_BITS-1:0];
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  // Sequence the Euclid rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      done_q      <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (r_cur_q == '0) begin
            state_q <= S_FINISH;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_status.done) begin
            state_q <= S_CHECK;
          end
        end
        S_FINISH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Load operands, advance the remainder and cofactor pairs, and capture the result
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      r_prev_q <= operand_value_i;
      r_cur_q  <= mod_q;
      c_prev_q <= CW'(1);
      c_cur_q  <= '0;
    end else if (state_q == S_WAIT && div_status.done) begin
      r_prev_q <= r_cur_q;
      r_cur_q  <= div_rem;
      c_prev_q <= c_cur_q;
      c_cur_q  <= c_prev_q - div_prod;
    end
    if (state_q == S_FINISH) begin
      inverse_q <= result_d;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign inverse_value_o = inverse_q;

  `MIE_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy,
                   "accepted request did not raise busy")
  `MIE_ASSERT_NEXT(a_done_single_pulse, done_o, !done_o,
                   "result strobe lasted more than one cycle")
  `MIE_ASSERT_NOW(a_no_restart_busy, div_start_q, !div_status.busy,
                  "divide unit restarted while busy")
  `MIE_ASSERT_NOW(a_div_done_in_wait, div_status.done, state_q == S_WAIT,
                  "divide unit finished outside the wait state")

endmodule
